@@ rtl/core/hsda_pkg.sv @@
// Shared types, constants and helper functions for the hydration shell
// dipole accumulator. Used by hsda_div and the top level; depends on nothing.
`default_nettype none

package hsda_pkg;

    // Fixed point and storage widths
    localparam int FRAC_BITS = 16;
    localparam int COUNT_W   = 16;
    localparam int ACC_W     = 48;
    localparam int MAG_W     = ACC_W - 1;

    // Stream and configuration widths
    localparam int IN_DATA_W  = 192;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 216;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Divider geometry: numerator, denominator and quotient widths
    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 63;
    localparam int DIV_Q_W   = 31;

    // Commands carried in tuser
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_WATER  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHELL_CUTOFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_ZERO_NORM = 2'd2;

    // Division jobs run at the end of an atom
    localparam logic [1:0] DIV_EXP  = 2'd0;
    localparam logic [1:0] DIV_MEAN = 2'd1;
    localparam logic [1:0] DIV_ORD  = 2'd2;
    localparam logic [1:0] DIV_ALN  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BEG_SQ,
        ST_BEG_RT,
        ST_WAT_SQ,
        ST_WAT_CUT,
        ST_WAT_GRD,
        ST_WAT_DIP,
        ST_WAT_RT,
        ST_WAT_DOT,
        ST_WAT_EXP,
        ST_FIN_SH,
        ST_FIN_SQ,
        ST_FIN_RT,
        ST_FIN_DOT,
        ST_FIN_DEN,
        ST_FIN_DIV,
        ST_OUT
    } state_t;

    // Result of one division
    typedef struct packed {
        logic               ovf;
        logic [DIV_Q_W-1:0] quot;
    } div_res_t;

    // Saturating counter increment
    function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
        cnt_inc = (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Clamp a dipole sum into a signed 32-bit field
    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = -hi - 1;
        if (v > hi) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsda_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Self-contained: needs no package and no other module.
`default_nettype none

module hsda_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [35:0] trial_rem;
    logic [35:0] trial;
    logic        ge;

    // Bring down two radicand bits and try the next root bit
    assign trial_rem = {rem_reg, rad_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign ge        = (trial_rem >= trial);

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? 34'(trial_rem - trial) : trial_rem[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ rtl/core/hsda_div.sv @@
// Iterative restoring divider with quotient overflow flag, one bit a cycle.
// Depends on hsda_pkg for widths and the result struct.
`default_nettype none

module hsda_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [hsda_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [hsda_pkg::DIV_DEN_W-1:0] den,
    output logic                                done,
    output hsda_pkg::div_res_t                  res
);
    import hsda_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic                 ovf_reg;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W-1:0] num_hi;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign num_hi = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
    assign trial  = {rem_reg, low_reg[DIV_Q_W-1]};
    assign ge     = (trial >= {1'b0, den_reg});

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIV_Q_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: upper numerator part seeds the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_hi;
            den_reg <= den;
            low_reg <= num[DIV_Q_W-1:0];
            q_reg   <= '0;
            ovf_reg <= (num_hi >= den);
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            low_reg <= {low_reg[DIV_Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = q_reg;

endmodule

`default_nettype wire

@@ rtl/core/hydration_shell_dipole_accumulator.sv @@
// Top level of the hydration shell dipole accumulator: sequencer, shared
// multiplier and accumulator. Depends on hsda_pkg, hsda_sqrt and hsda_div.
//
// Usage: items enter on the s_ channel, tuser carries the command (begin
// atom, water, finish). A begin item loads the atom position and surface
// normal and clears the sums. A water item is tested against the shell
// cutoff and the guard distance and, if in the shell, adds its dipole and
// dipole magnitude and may count as exposed. A finish item produces one
// result item on the m_ channel; other items produce none.
// One item is worked at a time and s_tready is low meanwhile. All products
// go through one 33x33 multiplier, one term per cycle; roots come from a
// bit-serial unit and quotients from a restoring divider. Skipped waters
// leave after the distance test; the time that a finish item takes is
// set by the normalize shift, one root and up to four divisions.
// The result item stays on m_tdata until m_tready; the next item is taken
// once it has left. Synchronous active-low reset clears the configuration
// to its defaults and all per-atom state to zero.
// Configuration writes are registered, with no read-back.
`default_nettype none

module hydration_shell_dipole_accumulator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [hsda_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hsda_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // vec_x, vec_y, vec_z, aux_x, aux_y, aux_z (32 bits each)
    input  wire logic [hsda_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [hsda_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // net_dipole_x/y/z (32 each), shell_waters (16), guard_rejected (16),
    // exposed_fraction (17), dipole_alignment (18), mean_net_dipole (31),
    // order_parameter (17), zero fill (5)
    output logic [hsda_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import hsda_pkg::*;

    localparam logic [16:0] ONE_Q = 17'(1 << FRAC_BITS);

    // Configuration
    logic [30:0] cutoff_reg;
    logic [30:0] guard_reg;
    logic [16:0] nzn_reg;

    // Per-atom state
    logic signed [31:0]      pos_reg  [3];
    logic signed [31:0]      norm_reg [3];
    logic [31:0]             nmag_reg;
    logic                    present_reg;
    logic signed [ACC_W-1:0] dsum_reg [3];
    logic [MAG_W-1:0]        magsum_reg;
    logic [COUNT_W-1:0]      acc_cnt_reg;
    logic [COUNT_W-1:0]      rej_cnt_reg;
    logic [COUNT_W-1:0]      exp_cnt_reg;

    // Working registers
    logic signed [32:0]      r_reg   [3];
    logic signed [31:0]      dip_reg [3];
    logic [ACC_W-1:0]        abs_reg [3];
    logic                    sgn_reg [3];
    logic [ACC_W-1:0]        or_reg;
    logic [4:0]              shift_reg;
    logic [30:0]             mshort_reg;
    logic [48:0]             dmag_reg;
    logic [DIV_DEN_W-1:0]    den_reg;
    logic [1:0]              div_idx_reg;
    logic                    div_run_reg;
    logic [16:0]             expfrac_reg;
    logic [30:0]             mean_reg;
    logic [16:0]             order_reg;
    logic [17:0]             align_reg;

    // Shared multiplier and accumulator
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_reg;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic [1:0] comp;

    logic s_fire;
    logic sum_state;
    logic last3;
    logic last1;
    logic sqrt_start;
    logic sqrt_done;
    logic [31:0] sqrt_root;
    logic div_start;
    logic div_done;
    div_res_t div_res;
    logic div_en;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic div_step_done;
    logic [16:0] frac_res;
    logic [30:0] mean_res;
    logic acc_neg;
    logic [63:0] dot_abs;
    logic [66:0] acc_negated;
    logic [47:0] magsum_add;
    logic beyond_cut;
    logic inside_guard;
    logic exposed_dot;

    assign s_fire = s_tvalid && s_tready;
    assign last3  = (step_reg == 2'd3);
    assign last1  = (step_reg == 2'd1);
    assign comp   = last3 ? 2'd0 : step_reg;

    always_comb begin
        case (state_reg) inside
            ST_BEG_SQ, ST_WAT_SQ, ST_WAT_DIP, ST_WAT_DOT, ST_FIN_SQ, ST_FIN_DOT:
                sum_state = 1'b1;
            default:
                sum_state = 1'b0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= 31'd229376;
            guard_reg  <= 31'd6554;
            nzn_reg    <= 17'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SHELL_CUTOFF:   cutoff_reg <= cfg_wdata;
                CFG_GUARD_DISTANCE: guard_reg  <= cfg_wdata;
                CFG_NEAR_ZERO_NORM: nzn_reg    <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // Distance and direction tests on stored products
    assign beyond_cut   = (acc_reg[65:0] > 66'(prod_reg[61:0]));
    assign inside_guard = (acc_reg[65:0] < 66'(prod_reg[61:0]));
    assign exposed_dot  = !acc_reg[66] && (acc_reg != '0);

    // Division job selection
    assign acc_negated = -acc_reg;
    assign acc_neg     = acc_reg[66];
    assign dot_abs     = acc_neg ? acc_negated[63:0] : acc_reg[63:0];

    always_comb begin
        case (div_idx_reg)
            DIV_EXP: begin
                div_en  = (acc_cnt_reg != '0);
                div_num = {48'd0, exp_cnt_reg, 16'd0};
                div_den = DIV_DEN_W'(acc_cnt_reg);
            end
            DIV_MEAN: begin
                div_en  = (acc_cnt_reg != '0);
                div_num = {31'd0, dmag_reg};
                div_den = DIV_DEN_W'(acc_cnt_reg);
            end
            DIV_ORD: begin
                div_en  = (acc_cnt_reg != '0) && (magsum_reg > MAG_W'(nzn_reg));
                div_num = {15'd0, dmag_reg, 16'd0};
                div_den = DIV_DEN_W'(magsum_reg);
            end
            default: begin
                div_en  = (dmag_reg > 49'(nzn_reg)) && (nmag_reg > 32'(nzn_reg))
                          && (mshort_reg != '0);
                div_num = {dot_abs, 16'd0};
                div_den = den_reg;
            end
        endcase
    end

    assign div_step_done = div_run_reg ? div_done : !div_en;
    assign frac_res = (div_res.ovf || (div_res.quot > 31'(ONE_Q))) ? ONE_Q
                                                                   : div_res.quot[16:0];
    assign mean_res = div_res.ovf ? 31'h7FFF_FFFF : div_res.quot;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        CMD_BEGIN:  state_next = ST_BEG_SQ;
                        CMD_WATER:  state_next = ST_WAT_SQ;
                        CMD_FINISH: state_next = ST_FIN_SH;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BEG_SQ:  if (last3) state_next = ST_BEG_RT;
            ST_BEG_RT:  if (sqrt_done) state_next = ST_IDLE;
            ST_WAT_SQ:  if (last3) state_next = ST_WAT_CUT;
            ST_WAT_CUT: if (last1) state_next = beyond_cut ? ST_IDLE : ST_WAT_GRD;
            ST_WAT_GRD: if (last1) state_next = inside_guard ? ST_IDLE : ST_WAT_DIP;
            ST_WAT_DIP: if (last3) state_next = ST_WAT_RT;
            ST_WAT_RT:  if (sqrt_done) state_next = present_reg ? ST_WAT_DOT : ST_IDLE;
            ST_WAT_DOT: if (last3) state_next = ST_WAT_EXP;
            ST_WAT_EXP: state_next = ST_IDLE;
            ST_FIN_SH:  if (or_reg[ACC_W-1:30] == '0) state_next = ST_FIN_SQ;
            ST_FIN_SQ:  if (last3) state_next = ST_FIN_RT;
            ST_FIN_RT:  if (sqrt_done) state_next = ST_FIN_DOT;
            ST_FIN_DOT: if (last3) state_next = ST_FIN_DEN;
            ST_FIN_DEN: if (last1) state_next = ST_FIN_DIV;
            ST_FIN_DIV: if (div_step_done && (div_idx_reg == DIV_ALN)) state_next = ST_OUT;
            ST_OUT:     if (m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    assign step_next = (state_next != state_reg) ? 2'd0
                     : (last3 ? 2'd3 : step_reg + 2'd1);

    // Handshake and unit starts
    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  m_tvalid = 1'b1;
            ST_BEG_RT, ST_WAT_RT, ST_FIN_RT: sqrt_start = (step_reg == 2'd0);
            ST_FIN_DIV: div_start = !div_run_reg && div_en;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_BEG_SQ: begin
                op_a = 33'(norm_reg[comp]);
                op_b = 33'(norm_reg[comp]);
            end
            ST_WAT_SQ: begin
                op_a = r_reg[comp];
                op_b = r_reg[comp];
            end
            ST_WAT_CUT: begin
                op_a = {2'b00, cutoff_reg};
                op_b = {2'b00, cutoff_reg};
            end
            ST_WAT_GRD: begin
                op_a = {2'b00, guard_reg};
                op_b = {2'b00, guard_reg};
            end
            ST_WAT_DIP: begin
                op_a = 33'(dip_reg[comp]);
                op_b = 33'(dip_reg[comp]);
            end
            ST_WAT_DOT: begin
                op_a = r_reg[comp];
                op_b = 33'(norm_reg[comp]);
            end
            ST_FIN_SQ: begin
                op_a = {3'b000, abs_reg[comp][29:0]};
                op_b = {3'b000, abs_reg[comp][29:0]};
            end
            ST_FIN_DOT: begin
                op_a = sgn_reg[comp] ? -{3'b000, abs_reg[comp][29:0]}
                                     : {3'b000, abs_reg[comp][29:0]};
                op_b = 33'(norm_reg[comp]);
            end
            ST_FIN_DEN: begin
                op_a = {2'b00, mshort_reg};
                op_b = {1'b0, nmag_reg};
            end
            default: ;
        endcase
    end

    // Multiply, then accumulate one term a cycle
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (sum_state) begin
            if (step_reg == 2'd0) begin
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_reg + 67'(prod_reg);
            end
        end
    end

    assign magsum_add = {1'b0, magsum_reg} + 48'(sqrt_root);

    // Per-atom state and sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]  <= '0;
                norm_reg[i] <= '0;
                dsum_reg[i] <= '0;
            end
            nmag_reg    <= '0;
            present_reg <= 1'b0;
            magsum_reg  <= '0;
            acc_cnt_reg <= '0;
            rej_cnt_reg <= '0;
            exp_cnt_reg <= '0;
        end else begin
            // Load atom and clear sums on begin
            if (s_fire && (s_tuser == CMD_BEGIN)) begin
                for (int i = 0; i < 3; i++) begin
                    pos_reg[i]  <= s_tdata[32*i +: 32];
                    norm_reg[i] <= s_tdata[96+32*i +: 32];
                    dsum_reg[i] <= '0;
                end
                magsum_reg  <= '0;
                acc_cnt_reg <= '0;
                rej_cnt_reg <= '0;
                exp_cnt_reg <= '0;
            end
            if ((state_reg == ST_BEG_RT) && sqrt_done) begin
                nmag_reg    <= sqrt_root;
                present_reg <= (sqrt_root > 32'(nzn_reg));
            end
            // Guard test decides rejected or in shell
            if ((state_reg == ST_WAT_GRD) && last1) begin
                if (inside_guard) begin
                    rej_cnt_reg <= cnt_inc(rej_cnt_reg);
                end else begin
                    acc_cnt_reg <= cnt_inc(acc_cnt_reg);
                    for (int i = 0; i < 3; i++) begin
                        logic signed [ACC_W:0] s;
                        s = {dsum_reg[i][ACC_W-1], dsum_reg[i]} + (ACC_W+1)'(dip_reg[i]);
                        if (s[ACC_W] != s[ACC_W-1]) begin
                            dsum_reg[i] <= s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                    : {1'b0, {(ACC_W-1){1'b1}}};
                        end else begin
                            dsum_reg[i] <= s[ACC_W-1:0];
                        end
                    end
                end
            end
            // Dipole magnitude into the saturating sum
            if ((state_reg == ST_WAT_RT) && sqrt_done) begin
                magsum_reg <= magsum_add[MAG_W] ? {MAG_W{1'b1}} : magsum_add[MAG_W-1:0];
                if (!present_reg) begin
                    exp_cnt_reg <= cnt_inc(exp_cnt_reg);
                end
            end
            if ((state_reg == ST_WAT_EXP) && exposed_dot) begin
                exp_cnt_reg <= cnt_inc(exp_cnt_reg);
            end
        end
    end

    // Working registers for water and finish items
    always_ff @(posedge aclk) begin
        if (s_fire && (s_tuser == CMD_WATER)) begin
            for (int i = 0; i < 3; i++) begin
                r_reg[i]   <= 33'(signed'(s_tdata[32*i +: 32])) - 33'(pos_reg[i]);
                dip_reg[i] <= s_tdata[96+32*i +: 32];
            end
        end
        // Take magnitudes of the sums and start the normalize search
        if (s_fire && (s_tuser == CMD_FINISH)) begin
            for (int i = 0; i < 3; i++) begin
                abs_reg[i] <= dsum_reg[i][ACC_W-1] ? ACC_W'(-dsum_reg[i]) : dsum_reg[i];
                sgn_reg[i] <= dsum_reg[i][ACC_W-1];
            end
            or_reg <= (dsum_reg[0][ACC_W-1] ? ACC_W'(-dsum_reg[0]) : dsum_reg[0])
                    | (dsum_reg[1][ACC_W-1] ? ACC_W'(-dsum_reg[1]) : dsum_reg[1])
                    | (dsum_reg[2][ACC_W-1] ? ACC_W'(-dsum_reg[2]) : dsum_reg[2]);
            shift_reg <= '0;
        end
        // Shift until every component is below 2^30
        if ((state_reg == ST_FIN_SH) && (or_reg[ACC_W-1:30] != '0)) begin
            or_reg    <= or_reg >> 1;
            shift_reg <= shift_reg + 5'd1;
            for (int i = 0; i < 3; i++) begin
                abs_reg[i] <= abs_reg[i] >> 1;
            end
        end
        if ((state_reg == ST_FIN_RT) && sqrt_done) begin
            mshort_reg <= sqrt_root[30:0];
            dmag_reg   <= 49'(sqrt_root[30:0]) << shift_reg;
        end
        if ((state_reg == ST_FIN_DEN) && last1) begin
            den_reg <= prod_reg[DIV_DEN_W-1:0];
        end
    end

    // Division jobs in turn
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_idx_reg <= DIV_EXP;
            div_run_reg <= 1'b0;
        end else if (state_reg == ST_FIN_DIV) begin
            if (div_start) begin
                div_run_reg <= 1'b1;
            end else if (div_step_done) begin
                div_run_reg <= 1'b0;
                div_idx_reg <= div_idx_reg + 2'd1;
            end
        end else begin
            div_idx_reg <= DIV_EXP;
            div_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN_DIV) && !div_start && div_step_done) begin
            case (div_idx_reg)
                DIV_EXP:  expfrac_reg <= div_en ? frac_res : '0;
                DIV_MEAN: mean_reg    <= div_en ? mean_res : '0;
                DIV_ORD:  order_reg   <= div_en ? frac_res : '0;
                default:  align_reg   <= !div_en ? '0
                                       : (acc_neg ? -{1'b0, frac_res} : {1'b0, frac_res});
            endcase
        end
    end

    hsda_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg[63:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    hsda_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .res     (div_res)
    );

    // Result item
    assign m_tdata = {5'd0, order_reg, mean_reg, align_reg, expfrac_reg,
                      rej_cnt_reg, acc_cnt_reg,
                      sat32(dsum_reg[2]), sat32(dsum_reg[1]), sat32(dsum_reg[0])};

endmodule

`default_nettype wire
